/* rtl/vnc_pkg.sv */
// Shared widths, codes and types for the nearest-center labeler.
package vnc_pkg;

  // Field widths
  localparam int COORD_W = 10;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 1;

  // Parameter defaults
  localparam int DEF_MAX_CELLS = 64;
  localparam int DEF_GRID_SIDE = 1024;

  // Reset value of the center count register
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP_A,
    ST_WRAP_B,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

/* rtl/vnc_if.sv */
// Valid/ready channel interfaces for input items and result items.
interface vnc_item_if;
  import vnc_pkg::*;

  logic                 valid;
  logic                 ready;
  mode_t                mode;
  logic [INDEX_W-1:0]   cell_index;
  logic [COORD_W-1:0]   coord_x;
  logic [COORD_W-1:0]   coord_y;

  modport source (output valid, mode, cell_index, coord_x, coord_y, input ready);
  modport sink   (input valid, mode, cell_index, coord_x, coord_y, output ready);
endinterface

interface vnc_result_if;
  import vnc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [INDEX_W-1:0]   nearest_cell;
  logic [DIST_W-1:0]    nearest_distance;
  logic [INDEX_W-1:0]   farthest_cell;
  logic [DIST_W-1:0]    farthest_distance;

  modport source (output valid, nearest_cell, nearest_distance, farthest_cell,
                  farthest_distance, input ready);
  modport sink   (input valid, nearest_cell, nearest_distance, farthest_cell,
                  farthest_distance, output ready);
endinterface

/* rtl/vnc_wrap.sv */
// Two-stage coordinate wrap: coordinate modulo the grid side by reciprocal multiply.
module vnc_wrap #(
  parameter int GRID_SIDE = vnc_pkg::DEF_GRID_SIDE
) (
  input  logic                        clk,
  input  logic [vnc_pkg::COORD_W-1:0] coord_in,
  output logic [vnc_pkg::COORD_W-1:0] coord_out
);
  import vnc_pkg::*;

  localparam int SHIFT   = 2 * COORD_W;
  localparam int RECIP_W = 2 * COORD_W;
  localparam int PROD_W  = COORD_W + RECIP_W;
  localparam int SIDE_W  = $clog2(GRID_SIDE + 1);
  localparam int FULL_W  = COORD_W + SIDE_W;

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << SHIFT) / GRID_SIDE);
  localparam logic [FULL_W-1:0]  SIDE  = FULL_W'(GRID_SIDE);

  logic [PROD_W-1:0]  prod;
  logic [COORD_W-1:0] x_a;
  logic [COORD_W-1:0] quot_a;
  logic [FULL_W-1:0]  back;
  logic [FULL_W-1:0]  rem;
  logic [FULL_W-1:0]  rem_fix;

  // Estimate the quotient; it is exact or one short
  assign prod = PROD_W'(coord_in) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    x_a    <= coord_in;
    quot_a <= prod[PROD_W-1:SHIFT];
  end

  // Take back the quotient and correct once
  always_comb begin
    back    = FULL_W'(quot_a) * SIDE;
    rem     = FULL_W'(x_a) - back;
    rem_fix = (rem >= SIDE) ? rem - SIDE : rem;
  end

  always_ff @(posedge clk) begin
    coord_out <= rem_fix[COORD_W-1:0];
  end

endmodule

/* rtl/voronoi_nearest_center_label.sv */
// Brute-force Voronoi labeler: center memory, distance scan and result register.
//
// Use: items arrive on the item channel (valid/ready). A load beat (mode 0)
// writes center (coord_x, coord_y) into slot cell_index and gives no result;
// slots at or above MAX_CELLS are dropped. A query beat (mode 1) gives a pixel
// and yields one beat on the result channel with the nearest and farthest of
// the first cell_count centers and their squared distances, lowest index on
// ties. cell_count is written through cfg_we/cfg_wdata; the user writes it only
// while the block is idle, which the block does not enforce. 0 counts as 1 and
// values above MAX_CELLS count as MAX_CELLS. Coordinates wrap modulo GRID_SIDE.
// Sequence: a load holds the item channel through the accept and the two wrap
// states. A query with N centers scans the center memory one slot per cycle,
// then drains the scan pipeline and loads the result register before the next
// item is taken; the single read port of the center memory sets the scan rate.
// Reset clears the control state and sets cell_count to 1; center slots hold
// nothing defined until loaded. A stalled result waits in the output register
// while the next item is accepted and worked; a finished query then holds until
// the result register is free.
module voronoi_nearest_center_label #(
  parameter int MAX_CELLS = vnc_pkg::DEF_MAX_CELLS,
  parameter int GRID_SIDE = vnc_pkg::DEF_GRID_SIDE
) (
  input  logic                        clk,
  input  logic                        rst,
  vnc_item_if.sink                    item,
  vnc_result_if.source                result,
  input  logic                        cfg_we,
  input  logic [vnc_pkg::COUNT_W-1:0] cfg_wdata
);
  import vnc_pkg::*;

  localparam int ADDR_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int ENTRY_W = 2 * COORD_W;

  // Control
  state_t              state;
  state_t              state_next;
  logic [COUNT_W-1:0]  cell_count;
  logic                accept;
  logic                mem_we;
  logic                start_scan;
  logic                rd_issue;
  logic                load_out;
  logic                slot_ok;

  // Captured item
  mode_t               cur_mode;
  logic [INDEX_W-1:0]  cur_index;
  logic [COORD_W-1:0]  wrap_x;
  logic [COORD_W-1:0]  wrap_y;
  logic [COORD_W-1:0]  px;
  logic [COORD_W-1:0]  py;

  // Center memory
  logic [ENTRY_W-1:0]  center_mem [0:MAX_CELLS-1];
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   last_idx;
  logic [ADDR_W-1:0]   last_next;
  logic [ENTRY_W-1:0]  rd_data;

  // Scan pipeline
  logic                s1_vld;
  logic                s1_first;
  logic [ADDR_W-1:0]   s1_idx;
  logic                s2_vld;
  logic                s2_first;
  logic [ADDR_W-1:0]   s2_idx;
  logic [COORD_W-1:0]  dx;
  logic [COORD_W-1:0]  dy;
  logic [SQ_W-1:0]     sq_x;
  logic [SQ_W-1:0]     sq_y;
  logic [DIST_W-1:0]   pair_dist;

  // Running extremes
  logic [DIST_W-1:0]   near_d;
  logic [DIST_W-1:0]   far_d;
  logic [ADDR_W-1:0]   near_k;
  logic [ADDR_W-1:0]   far_k;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count <= COUNT_RESET;
    end else if (cfg_we) begin
      cell_count <= cfg_wdata;
    end
  end

  // Clamp the count to 1..MAX_CELLS and turn it into the last slot scanned
  always_comb begin
    if (cell_count == '0) begin
      last_next = '0;
    end else if (int'(cell_count) > MAX_CELLS) begin
      last_next = ADDR_W'(MAX_CELLS - 1);
    end else begin
      last_next = ADDR_W'(cell_count - COUNT_W'(1));
    end
  end

  // Wrap both coordinates
  vnc_wrap #(.GRID_SIDE(GRID_SIDE)) u_wrap_x (
    .clk       (clk),
    .coord_in  (item.coord_x),
    .coord_out (wrap_x)
  );

  vnc_wrap #(.GRID_SIDE(GRID_SIDE)) u_wrap_y (
    .clk       (clk),
    .coord_in  (item.coord_y),
    .coord_out (wrap_y)
  );

  assign accept  = item.valid && item.ready;
  assign slot_ok = int'(cur_index) < MAX_CELLS;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item.valid) state_next = ST_WRAP_A;
      end
      ST_WRAP_A: state_next = ST_WRAP_B;
      ST_WRAP_B: begin
        state_next = (cur_mode == MODE_QUERY) ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (rd_addr == last_idx) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!s1_vld && !s2_vld && (!result.valid || result.ready)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    item.ready = 1'b0;
    mem_we     = 1'b0;
    start_scan = 1'b0;
    rd_issue   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE:   item.ready = 1'b1;
      ST_WRAP_A: ;
      ST_WRAP_B: begin
        mem_we     = (cur_mode == MODE_LOAD) && slot_ok;
        start_scan = (cur_mode == MODE_QUERY);
      end
      ST_SCAN:   rd_issue = 1'b1;
      ST_FINISH: load_out = !s1_vld && !s2_vld && (!result.valid || result.ready);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the item's mode and slot
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_mode  <= item.mode;
      cur_index <= item.cell_index;
    end
  end

  // Hold the query pixel and scan bounds
  always_ff @(posedge clk) begin
    if (start_scan) begin
      px       <= wrap_x;
      py       <= wrap_y;
      last_idx <= last_next;
    end
  end

  // Advance the read address
  always_ff @(posedge clk) begin
    if (start_scan) begin
      rd_addr <= '0;
    end else if (rd_issue && rd_addr != last_idx) begin
      rd_addr <= rd_addr + ADDR_W'(1);
    end
  end

  // Center memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      center_mem[ADDR_W'(cur_index)] <= {wrap_x, wrap_y};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_data <= center_mem[rd_addr];
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= rd_issue;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx   <= rd_addr;
    s1_first <= (rd_addr == '0);
    s2_idx   <= s1_idx;
    s2_first <= s1_first;
  end

  // Square the coordinate differences
  always_comb begin
    dx = (px >= rd_data[ENTRY_W-1:COORD_W]) ? px - rd_data[ENTRY_W-1:COORD_W]
                                            : rd_data[ENTRY_W-1:COORD_W] - px;
    dy = (py >= rd_data[COORD_W-1:0]) ? py - rd_data[COORD_W-1:0]
                                      : rd_data[COORD_W-1:0] - py;
  end

  always_ff @(posedge clk) begin
    sq_x <= SQ_W'(dx) * SQ_W'(dx);
    sq_y <= SQ_W'(dy) * SQ_W'(dy);
  end

  assign pair_dist = DIST_W'(sq_x) + DIST_W'(sq_y);

  // Track nearest and farthest; strict compares keep the lowest index on ties
  always_ff @(posedge clk) begin
    if (s2_vld) begin
      if (s2_first) begin
        near_d <= pair_dist;
        near_k <= s2_idx;
        far_d  <= pair_dist;
        far_k  <= s2_idx;
      end else begin
        if (pair_dist < near_d) begin
          near_d <= pair_dist;
          near_k <= s2_idx;
        end
        if (pair_dist > far_d) begin
          far_d <= pair_dist;
          far_k <= s2_idx;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.nearest_cell      <= INDEX_W'(near_k);
      result.nearest_distance  <= near_d;
      result.farthest_cell     <= INDEX_W'(far_k);
      result.farthest_distance <= far_d;
    end
  end

  // No scan beats in flight while a new item can be taken
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> (!s1_vld && !s2_vld))
    else $error("scan pipeline busy while item channel is ready");

  // Read address never runs past the last slot of the query
  a_addr_bound: assert property (@(posedge clk) disable iff (rst)
    rd_issue |-> (rd_addr <= last_idx))
    else $error("center read beyond configured count");

  // A fresh result has nearest no farther than farthest
  a_order: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (result.nearest_distance <= result.farthest_distance))
    else $error("nearest distance exceeds farthest distance");

endmodule
